### src/assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

### src/sgpk_pkg.sv
`default_nettype none

package sgpk_pkg;

  localparam int LEVEL_W = 5;
  localparam int INDEX_W = 32;
  localparam int HASH_W  = 64;
  localparam int SUM_W   = 16;

  localparam logic [HASH_W-1:0]  HASH_SEED = 64'h0000_0000_dead_beef;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = '1;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [INDEX_W-1:0] point_index;
    logic [LEVEL_W-1:0] other_level;
    logic [INDEX_W-1:0] other_index;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [SUM_W-1:0]   sum;
    logic [LEVEL_W-1:0] max;
    logic [LEVEL_W-1:0] min;
    logic               equal;
    logic               ancestor;
  } acc_t;

  localparam acc_t ACC_RESET = '{
    hash:     HASH_SEED,
    sum:      '0,
    max:      '0,
    min:      LEVEL_TOP,
    equal:    1'b1,
    ancestor: 1'b1
  };

endpackage

`default_nettype wire

### src/sparse_grid_point_key_unit.sv
// Sparse-grid point key unit. A point arrives one dimension per transaction
// (level and index of the point, level and index of a second point); the
// transaction with last set closes the point and yields one result with the
// 64-bit multiplicative hash, saturating level sum, level max/min, the inner
// flag and the equal/ancestor flags, after which the running state returns
// to its start values. Throughput is one dimension per clock unless a result
// stalls. The result is registered as the last dimension leaves the input
// register. The input and single-entry result registers are the only
// buffering; a stalled result blocks input at the next last dimension.
`default_nettype none

module sparse_grid_point_key_unit
  import sgpk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic [INDEX_W-1:0] point_index,
  input  wire logic [LEVEL_W-1:0] other_level,
  input  wire logic [INDEX_W-1:0] other_index,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [HASH_W-1:0]       hash,
  output logic [SUM_W-1:0]        level_sum,
  output logic [LEVEL_W-1:0]      level_max,
  output logic [LEVEL_W-1:0]      level_min,
  output logic                    inner,
  output logic                    equal,
  output logic                    ancestor
);

  logic  s1_valid;
  item_t s1;
  acc_t  acc;
  acc_t  acc_fold;
  logic  s1_fire;

  sgpk_fold u_fold (
    .acc      (acc),
    .item     (s1),
    .acc_next (acc_fold)
  );

  // Only a closing dimension needs room in the result register.
  assign s1_fire  = s1_valid && (!s1.last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      acc       <= ACC_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_fire) begin
        acc <= s1.last ? ACC_RESET : acc_fold;
      end
      if (s1_fire && s1.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1.level       <= level;
      s1.point_index <= point_index;
      s1.other_level <= other_level;
      s1.other_index <= other_index;
      s1.last        <= last;
    end
    if (s1_fire && s1.last) begin
      hash      <= acc_fold.hash;
      level_sum <= acc_fold.sum;
      level_max <= acc_fold.max;
      level_min <= acc_fold.min;
      inner     <= (acc_fold.min != '0);
      equal     <= acc_fold.equal;
      ancestor  <= acc_fold.ancestor;
    end
  end

endmodule

`default_nettype wire

### src/sgpk_fold.sv
`default_nettype none

// Folds one dimension into the running point state.
module sgpk_fold
  import sgpk_pkg::*;
(
  input  wire acc_t  acc,
  input  wire item_t item,
  output acc_t       acc_next
);

  logic [INDEX_W-1:0] term;
  logic [HASH_W-1:0]  scaled;
  logic [SUM_W:0]     sum_wide;
  logic [LEVEL_W-1:0] shift;
  logic               anc;

  always_comb begin
    term = (INDEX_W'(1) << item.level) + item.point_index;
    // 65599 = 2^16 + 2^6 - 1
    scaled = (acc.hash << 16) + (acc.hash << 6) - acc.hash;
    acc_next.hash = scaled + HASH_W'(term);

    sum_wide = {1'b0, acc.sum} + (SUM_W+1)'(item.level);
    acc_next.sum = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    acc_next.max = (item.level > acc.max) ? item.level : acc.max;
    acc_next.min = (item.level < acc.min) ? item.level : acc.min;

    acc_next.equal = acc.equal && (item.level == item.other_level)
                     && (item.point_index == item.other_index);

    shift = item.other_level - item.level;
    anc = (item.other_level >= item.level)
          && (item.point_index == ((item.other_index >> shift) | INDEX_W'(1)));
    acc_next.ancestor = acc.ancestor && anc;
  end

endmodule

`default_nettype wire

### src/sgpk_checker.sv
`default_nettype none
`include "assert_macros.svh"

module sgpk_checker
  import sgpk_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [HASH_W-1:0]  hash,
  input wire logic [SUM_W-1:0]   level_sum,
  input wire logic [LEVEL_W-1:0] level_max,
  input wire logic [LEVEL_W-1:0] level_min,
  input wire logic               inner
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hash))
  `ASSERT_SAME(a_inner_min, out_valid, inner == (level_min != '0))
  `ASSERT_SAME(a_max_ge_min, out_valid, level_max >= level_min)
  `ASSERT_SAME(a_sum_ge_max, out_valid, level_sum >= SUM_W'(level_max))

endmodule

bind sparse_grid_point_key_unit sgpk_checker u_sgpk_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hash      (hash),
  .level_sum (level_sum),
  .level_max (level_max),
  .level_min (level_min),
  .inner     (inner)
);

`default_nettype wire
